### src/alsid_pkg.sv
package alsid_pkg;

  // Number of words the list can hold.
  localparam int CAPACITY = 128;

  // Index into the store, and a count that can also hold CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Field widths on the ports.
  localparam int POS_W  = 8;
  localparam int FIDX_W = 7;
  localparam int LEN_W  = 8;
  localparam int WORD_W = 32;

  // Common width for comparing a position with the count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    MODE_LOCATE = 2'd0,
    MODE_MODIFY = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_EMPTY_FULL = 2'd2,
    ST_BAD_POS    = 2'd3
  } status_t;

  // One cycle's worth of requests to the word store.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

  // Position field narrowed or widened to a store index.
  function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] pos);
    logic [CMP_W+IDX_W-1:0] wide;
    wide = (CMP_W + IDX_W)'(pos);
    return wide[IDX_W-1:0];
  endfunction

  // Store index shown in the found_index field.
  function automatic logic [FIDX_W-1:0] idx_to_fidx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+FIDX_W-1:0] wide;
    wide = (IDX_W + FIDX_W)'(idx);
    return wide[FIDX_W-1:0];
  endfunction

  // Count shown in the list_length field.
  function automatic logic [LEN_W-1:0] cnt_to_len(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+LEN_W-1:0] wide;
    wide = (CNT_W + LEN_W)'(cnt);
    return wide[LEN_W-1:0];
  endfunction

endpackage

### src/array_list_search_insert_delete_core.sv
// Ordered list of signed 32-bit words in a single-port-read, single-port-write
// store of alsid_pkg::CAPACITY entries, with a length count that reset clears,
// so the list starts empty. Each input word carries an operation in s_tuser:
// locate returns the index of the first entry equal to key, modify overwrites
// that entry with new_value, insert places new_value at position and moves the
// tail up by one, and delete returns the entry at position and moves the tail
// down. One output word follows every input word, carrying a status in m_tuser
// (ok, not found, list empty or full, bad position), the match index, the
// removed word and the length after the operation. The block works on one word
// at a time and walks the store one entry per cycle, since the store offers one
// read and one write per cycle: locate and modify walk up to the whole list,
// insert and delete walk the entries from position to the end of the list, and
// a rejected word goes straight to its result. Any result also waits while the
// previous result still waits on the output. A new input word is taken while
// the previous result still waits on the output.
module array_list_search_insert_delete_core (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // key[31:0], new_value[63:32], position[71:64]
  input  logic [1:0]  s_tuser,   // mode[1:0]

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // found_index[6:0], removed_value[38:7],
                                 // list_length[46:39], zero[47]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int IDX_W  = alsid_pkg::IDX_W;
  localparam int CNT_W  = alsid_pkg::CNT_W;
  localparam int CMP_W  = alsid_pkg::CMP_W;
  localparam int WORD_W = alsid_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_DEL,
    S_FINISH
  } state_t;

  state_t state;

  // Latched operation.
  alsid_pkg::mode_t         op_mode;
  logic signed [WORD_W-1:0] op_key;
  logic signed [WORD_W-1:0] op_nval;
  logic [alsid_pkg::POS_W-1:0] op_pos;

  // Walk control: walk is the next entry to read (for insert, one above it), pend
  // marks that the store's read data for entry pend_idx arrives this cycle.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] walk;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;

  // Result being built.
  alsid_pkg::status_t       res_status;
  logic [IDX_W-1:0]         res_idx;
  logic signed [WORD_W-1:0] res_removed;

  alsid_pkg::mem_req_t  mem_req;
  logic [WORD_W-1:0]    rd_data;

  alsid_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Input fields as they arrive.
  alsid_pkg::mode_t            in_mode;
  logic [alsid_pkg::POS_W-1:0] in_pos;
  logic [CMP_W-1:0]            in_pos_ext;
  logic [CMP_W-1:0]            count_ext;
  logic                        in_take;

  assign in_mode    = alsid_pkg::mode_t'(s_tuser);
  assign in_pos     = s_tdata[71:64];
  assign in_pos_ext = CMP_W'(in_pos);
  assign count_ext  = CMP_W'(count);
  assign s_tready   = (state == S_IDLE);
  assign in_take    = s_tvalid && s_tready;

  logic [CMP_W-1:0] op_pos_ext;
  logic [CMP_W-1:0] walk_ext;
  logic [IDX_W-1:0] op_pos_idx;
  logic [CNT_W-1:0] walk_m1;
  logic             issue;
  logic             hit;
  logic             out_free;

  assign op_pos_ext = CMP_W'(op_pos);
  assign walk_ext   = CMP_W'(walk);
  assign op_pos_idx = alsid_pkg::pos_to_idx(op_pos);
  assign walk_m1    = walk - 1'b1;
  assign hit        = pend && (rd_data == op_key);
  assign out_free   = !m_tvalid || m_tready;

  // A read is started while entries remain to be walked.
  always_comb begin
    case (state)
      S_SCAN:  issue = (walk < count);
      S_INS:   issue = (walk_ext > op_pos_ext);
      S_DEL:   issue = (walk < count);
      default: issue = 1'b0;
    endcase
  end

  // Store requests: insert walks downwards, everything else upwards.
  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = issue;
    mem_req.rd_addr = (state == S_INS) ? walk_m1[IDX_W-1:0] : walk[IDX_W-1:0];
    case (state)
      S_SCAN: begin
        mem_req.wr_en   = hit && (op_mode == alsid_pkg::MODE_MODIFY);
        mem_req.wr_addr = pend_idx;
        mem_req.wr_data = op_nval;
      end
      S_INS: begin
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = IDX_W'(pend_idx + 1'b1);
          mem_req.wr_data = rd_data;
        end else if (!issue) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = op_pos_idx;
          mem_req.wr_data = op_nval;
        end
      end
      S_DEL: begin
        mem_req.wr_en   = pend && (pend_idx != op_pos_idx);
        mem_req.wr_addr = IDX_W'(pend_idx - 1'b1);
        mem_req.wr_data = rd_data;
      end
      default: begin
        mem_req.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // The output word is loaded when the result is ready and the register
      // is free, and dropped once it has been taken.
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      pend     <= issue;
      pend_idx <= mem_req.rd_addr;
      case (state)
        S_IDLE: begin
          if (in_take) begin
            op_mode     <= in_mode;
            op_key      <= s_tdata[31:0];
            op_nval     <= s_tdata[63:32];
            op_pos      <= in_pos;
            res_status  <= alsid_pkg::ST_OK;
            res_idx     <= '0;
            res_removed <= '0;
            case (in_mode)
              alsid_pkg::MODE_LOCATE, alsid_pkg::MODE_MODIFY: begin
                walk <= '0;
                if (count == '0) begin
                  res_status <= alsid_pkg::ST_EMPTY_FULL;
                  state      <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
              alsid_pkg::MODE_INSERT: begin
                walk <= count;
                if (in_pos_ext > count_ext && count != CNT_W'(alsid_pkg::CAPACITY)) begin
                  res_status <= alsid_pkg::ST_BAD_POS;
                  state      <= S_FINISH;
                end else if (count == CNT_W'(alsid_pkg::CAPACITY)) begin
                  res_status <= alsid_pkg::ST_EMPTY_FULL;
                  state      <= S_FINISH;
                end else begin
                  state <= S_INS;
                end
              end
              alsid_pkg::MODE_DELETE: begin
                walk <= in_pos_ext[CNT_W-1:0];
                if (count != '0 && in_pos_ext >= count_ext) begin
                  res_status <= alsid_pkg::ST_BAD_POS;
                  state      <= S_FINISH;
                end else if (count == '0) begin
                  res_status <= alsid_pkg::ST_EMPTY_FULL;
                  state      <= S_FINISH;
                end else begin
                  state <= S_DEL;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            walk <= walk + 1'b1;
          end
          if (hit) begin
            res_idx <= pend_idx;
            state   <= S_FINISH;
          end else if (!pend && !issue) begin
            res_status <= alsid_pkg::ST_NOT_FOUND;
            state      <= S_FINISH;
          end
        end
        S_INS: begin
          if (issue) begin
            walk <= walk_m1;
          end
          if (!pend && !issue) begin
            count <= count + 1'b1;
            state <= S_FINISH;
          end
        end
        S_DEL: begin
          if (issue) begin
            walk <= walk + 1'b1;
          end
          if (pend && pend_idx == op_pos_idx) begin
            res_removed <= rd_data;
          end
          if (!pend && !issue) begin
            count <= count - 1'b1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tuser  <= res_status;
            m_tdata  <= {1'b0, alsid_pkg::cnt_to_len(count), res_removed,
                         alsid_pkg::idx_to_fidx(res_idx)};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(alsid_pkg::CAPACITY))
    else $error("list count beyond capacity");

  // The count moves by at most one per operation.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == CNT_W'($past(count) + 1'b1) || count == CNT_W'($past(count) - 1'b1)))
    else $error("list count jumped");

  // A shift never writes the entry it reads in the same cycle.
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("store read and write collide");

  // The downward walk of an insert stops at the insert position.
  a_ins_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (walk_ext >= op_pos_ext))
    else $error("insert walk went below position");

endmodule

### src/alsid_store.sv
module alsid_store (
  input  logic                         clk,
  input  alsid_pkg::mem_req_t          req,
  output logic [alsid_pkg::WORD_W-1:0] rd_data
);

  logic [alsid_pkg::WORD_W-1:0] mem [alsid_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
